>>> hdl/gst_pkg.sv
// Shared constants, request codes and word types for the group set table.
`default_nettype none
package gst_pkg;

    localparam int TABLE_SLOTS = 16;
    localparam int ID_W        = 16;
    localparam int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);

    typedef enum logic [1:0] {
        REQ_ENTER = 2'd0,
        REQ_LEAVE = 2'd1,
        REQ_QUERY = 2'd2
    } req_code_t;

    typedef struct packed {
        logic [1:0]      req_type;
        logic [ID_W-1:0] group_id;
    } in_word_t;

    typedef struct packed {
        logic is_member;
        logic table_full;
        logic was_present;
    } out_word_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [ID_W-1:0]  wr_data;
        logic [IDX_W-1:0] rd_addr;
    } mem_req_t;

endpackage
`default_nettype wire

>>> hdl/gst_ram.sv
// Entry store: one write port, one read port with registered read data.
`default_nettype none
module gst_ram (
    input  logic                        clk,
    input  gst_pkg::mem_req_t           mem_req,
    output logic [gst_pkg::ID_W-1:0]    rd_data
);
    import gst_pkg::*;

    logic [ID_W-1:0] entry_mem [TABLE_SLOTS];
    logic [ID_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            entry_mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
        rd_data_reg <= entry_mem[mem_req.rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

>>> hdl/gst_ctrl.sv
// Request sequencer: scans the packed entries, inserts, or shifts entries down on leave.
`default_nettype none
module gst_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  gst_pkg::in_word_t           request,
    input  logic [gst_pkg::ID_W-1:0]    primary_group,
    input  logic [gst_pkg::ID_W-1:0]    rd_data,
    output gst_pkg::mem_req_t           mem_req,
    output logic                        busy,
    output logic                        done,
    output gst_pkg::out_word_t          result
);
    import gst_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_SHIFT = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [1:0]       req_reg, req_next;
    logic [ID_W-1:0]  id_reg, id_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic             done_reg, done_next;
    out_word_t        result_reg, result_next;

    logic hit;
    logic issue;

    assign hit   = pend_reg && (rd_data == id_reg);
    assign issue = rd_idx_reg < cnt_reg;

    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        id_next       = id_reg;
        cnt_next      = cnt_reg;
        rd_idx_next   = rd_idx_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        mem_req       = '0;
        mem_req.rd_addr = rd_idx_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next    = request.req_type;
                    id_next     = request.group_id;
                    rd_idx_next = '0;
                    if (request.req_type == REQ_ENTER || request.req_type == REQ_LEAVE ||
                        request.req_type == REQ_QUERY)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        // unused code: no change, all-zero result
                        done_next   = 1'b1;
                        result_next = '0;
                    end
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    result_next = '0;
                    unique case (req_code_t'(req_reg))
                        REQ_ENTER:
                        begin
                            result_next.was_present = 1'b1;
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        REQ_LEAVE:
                        begin
                            // move every later entry down one slot
                            rd_idx_next = CNT_W'(pend_idx_reg) + CNT_W'(1);
                            state_next  = S_SHIFT;
                        end
                        REQ_QUERY:
                        begin
                            result_next.is_member = 1'b1;
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        default:
                        begin
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    endcase
                end
                else if (!issue && !pend_reg)
                begin
                    result_next = '0;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                    unique case (req_code_t'(req_reg))
                        REQ_ENTER:
                        begin
                            if (cnt_reg < CNT_W'(TABLE_SLOTS))
                            begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = cnt_reg[IDX_W-1:0];
                                mem_req.wr_data = id_reg;
                                cnt_next        = cnt_reg + CNT_W'(1);
                            end
                            else
                            begin
                                result_next.table_full = 1'b1;
                            end
                        end
                        REQ_QUERY:
                        begin
                            result_next.is_member = (id_reg == primary_group);
                        end
                        REQ_LEAVE:
                        begin
                            result_next = '0;
                        end
                        default:
                        begin
                            result_next = '0;
                        end
                    endcase
                end
                else if (issue)
                begin
                    rd_idx_next   = rd_idx_reg + CNT_W'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg[IDX_W-1:0];
                end
            end
            S_SHIFT:
            begin
                if (pend_reg)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = pend_idx_reg - IDX_W'(1);
                    mem_req.wr_data = rd_data;
                end
                if (issue)
                begin
                    rd_idx_next   = rd_idx_reg + CNT_W'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg[IDX_W-1:0];
                end
                else if (!pend_reg)
                begin
                    // drop the last used slot
                    cnt_next    = cnt_reg - CNT_W'(1);
                    result_next = '0;
                    result_next.was_present = 1'b1;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            pend_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            pend_reg   <= pend_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        id_reg       <= id_next;
        rd_idx_reg   <= rd_idx_next;
        pend_idx_reg <= pend_idx_next;
        result_reg   <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(TABLE_SLOTS))
        else $error("fill count beyond table size");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && result_reg.table_full |-> cnt_reg == CNT_W'(TABLE_SLOTS))
        else $error("full reported with an empty slot");

    a_write_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en |-> state_reg != S_IDLE)
        else $error("entry write while idle");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != $past(cnt_reg) |->
            (cnt_reg == $past(cnt_reg) + CNT_W'(1)) || (cnt_reg == $past(cnt_reg) - CNT_W'(1)))
        else $error("fill count moved by more than one");

endmodule
`default_nettype wire

>>> hdl/group_set_table.sv
// Top level of the group set table: config register, sequencer and entry store.
//
// Each request (enter, leave, query) gives one result word, strobed by done for one
// cycle; the receiver cannot stall it. A request is taken when start is high and busy
// is low. A request scans the used slots of the entry store, one slot read per cycle
// from its one read port with registered read data, and a leave that finds its entry
// adds a shift pass of one move per later entry. An unused request code answers with
// all zeros. The table is empty after reset with no clearing pass; primary_group may
// be written at any idle time and is always ready.
`default_nettype none
module group_set_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  gst_pkg::in_word_t           request,
    output logic                        busy,
    output logic                        done,
    output gst_pkg::out_word_t          result,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [gst_pkg::ID_W-1:0]    cfg_data
);
    import gst_pkg::*;

    logic [ID_W-1:0] primary_reg;
    logic [ID_W-1:0] rd_data;
    mem_req_t        mem_req;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primary_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            primary_reg <= cfg_data;
        end
    end

    gst_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .request       (request),
        .primary_group (primary_reg),
        .rd_data       (rd_data),
        .mem_req       (mem_req),
        .busy          (busy),
        .done          (done),
        .result        (result)
    );

    gst_ram u_ram (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

endmodule
`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for group_set_table: enter/leave/query requests, primary group writes.
`timescale 1ns / 100ps

module testbench;
    import gst_pkg::*;

    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam int POOL_N        = 22;
    localparam int PHASES        = 5;
    localparam int PHASE_ITEMS   = 150;
    localparam int SETTLE_CYCLES = 2 * TABLE_SLOTS + 8;
    localparam int RUN_LIMIT_NS  = 5_000_000;

    // Shadow copy of the group table; predicts one answer word per accepted request.
    class group_set_shadow;
        logic [ID_W-1:0] slot_id [TABLE_SLOTS];
        bit              slot_used [TABLE_SLOTS];
        logic [ID_W-1:0] primary;
        out_word_t       answers_due [$];
        int              mismatches;
        int              n_requests;
        int              n_full;
        int              n_present;
        int              n_member;

        function new();
            foreach (slot_used[i])
            begin
                slot_used[i] = 1'b0;
                slot_id[i]   = '0;
            end
            primary    = '0;
            mismatches = 0;
            n_requests = 0;
            n_full     = 0;
            n_present  = 0;
            n_member   = 0;
        endfunction

        function int find_id(logic [ID_W-1:0] id);
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                if (slot_used[i] && slot_id[i] == id)
                    return i;
            end
            return -1;
        endfunction

        function void note_request(in_word_t w);
            out_word_t ans;
            int        pos;
            ans = '0;
            n_requests++;
            case (w.req_type)
                REQ_ENTER:
                begin
                    pos = find_id(w.group_id);
                    if (pos >= 0)
                        ans.was_present = 1'b1;
                    else
                    begin
                        for (int i = 0; i < TABLE_SLOTS && pos < 0; i++)
                        begin
                            if (!slot_used[i])
                                pos = i;
                        end
                        if (pos >= 0)
                        begin
                            slot_id[pos]   = w.group_id;
                            slot_used[pos] = 1'b1;
                        end
                        else
                            ans.table_full = 1'b1;
                    end
                end
                REQ_LEAVE:
                begin
                    pos = find_id(w.group_id);
                    if (pos >= 0)
                    begin
                        ans.was_present = 1'b1;
                        // shift later entries down, empty the last slot
                        for (int i = pos; i < TABLE_SLOTS - 1; i++)
                        begin
                            slot_id[i]   = slot_id[i + 1];
                            slot_used[i] = slot_used[i + 1];
                        end
                        slot_used[TABLE_SLOTS - 1] = 1'b0;
                    end
                end
                REQ_QUERY:
                begin
                    ans.is_member = (w.group_id == primary) || (find_id(w.group_id) >= 0);
                end
                default:
                begin
                end
            endcase
            n_full    += ans.table_full;
            n_present += ans.was_present;
            n_member  += ans.is_member;
            answers_due.push_back(ans);
        endfunction

        function void check_answer(out_word_t got);
            out_word_t want;
            if (answers_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: result word %b with no request outstanding", $time, got);
                return;
            end
            want = answers_due.pop_front();
            if (got.is_member !== want.is_member)
            begin
                mismatches++;
                $display("%0t: is_member expected %b actual %b", $time,
                         want.is_member, got.is_member);
            end
            if (got.table_full !== want.table_full)
            begin
                mismatches++;
                $display("%0t: table_full expected %b actual %b", $time,
                         want.table_full, got.table_full);
            end
            if (got.was_present !== want.was_present)
            begin
                mismatches++;
                $display("%0t: was_present expected %b actual %b", $time,
                         want.was_present, got.was_present);
            end
        endfunction
    endclass

    logic            clk;
    logic            rst_n;
    logic            start;
    in_word_t        request;
    logic            busy;
    logic            done;
    out_word_t       result;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [ID_W-1:0] cfg_data;

    group_set_shadow shadow;
    int              steady_left;
    logic [ID_W-1:0] id_pool [POOL_N];

    group_set_table u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .request   (request),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            shadow.check_answer(result);
    end

    task automatic issue_request(input logic [1:0] kind, input logic [ID_W-1:0] id);
        in_word_t w;
        int       gap;
        w.req_type = kind;
        w.group_id = id;
        // mostly random gaps, with occasional back-to-back stretches
        if (steady_left > 0)
        begin
            gap = 0;
            steady_left--;
        end
        else if ($urandom_range(0, 15) == 0)
        begin
            steady_left = $urandom_range(8, 40);
            gap = 0;
        end
        else
            gap = $urandom_range(0, 17);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= w;
        do
            @(posedge clk);
        while (busy);
        shadow.note_request(w);
    endtask

    // Drop start and hold until every answer word has come back and the block is idle.
    task automatic drain();
        start <= 1'b0;
        while (shadow.answers_due.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_primary(input logic [ID_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        shadow.primary = value;
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return id_pool[$urandom_range(0, POOL_N - 1)];
        else if (r == 7)
            return shadow.primary;
        else if (r == 8)
            return ID_W'($urandom_range(0, 65535));
        else
            return ($urandom_range(0, 1) == 1) ? {ID_W{1'b1}} : {ID_W{1'b0}};
    endfunction

    initial
    begin
        logic [ID_W-1:0] prim [PHASES];
        int              enter_w [PHASES];
        int              r;
        logic [1:0]      kind;

        shadow      = new();
        steady_left = 0;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        request   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;

        foreach (id_pool[i])
            id_pool[i] = ID_W'($urandom_range(0, 65535));
        id_pool[0] = {ID_W{1'b0}};
        id_pool[1] = {ID_W{1'b1}};

        prim[0] = {ID_W{1'b1}};
        prim[1] = {ID_W{1'b0}};
        prim[2] = ID_W'($urandom_range(0, 65535));
        prim[3] = id_pool[$urandom_range(0, POOL_N - 1)];
        prim[4] = ID_W'($urandom_range(0, 65535));
        enter_w = '{45, 60, 30, 55, 40};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: primary still at its reset value of zero
        issue_request(REQ_QUERY, 16'h0000);
        issue_request(REQ_ENTER, 16'hFFFF);
        issue_request(REQ_ENTER, 16'hFFFF);
        issue_request(REQ_LEAVE, 16'h1234);
        issue_request(REQ_QUERY, 16'hFFFF);
        issue_request(REQ_UNUSED, 16'hAAAA);
        issue_request(REQ_QUERY, 16'h5555);
        // fill the table to the last slot, then overflow it
        for (int i = 0; i < TABLE_SLOTS - 1; i++)
            issue_request(REQ_ENTER, ID_W'(i) * 16'h0101);
        issue_request(REQ_ENTER, 16'h8000);
        issue_request(REQ_LEAVE, 16'hFFFF);
        issue_request(REQ_ENTER, 16'h8000);
        issue_request(REQ_LEAVE, 16'h8000);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            write_primary(prim[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < enter_w[ph])
                    kind = REQ_ENTER;
                else if (r < 70)
                    kind = REQ_LEAVE;
                else if (r < 97)
                    kind = REQ_QUERY;
                else
                    kind = REQ_UNUSED;
                issue_request(kind, pick_id());
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d requests over %0d primary group settings.",
                 shadow.n_requests, PHASES + 1);
        $display("Answers: %0d full, %0d already stored, %0d members.",
                 shadow.n_full, shadow.n_present, shadow.n_member);
        if (shadow.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
